// File: rtl/core/dpmst_pkg.sv
// Shared types and constants of the dense Prim spanning tree core.
package dpmst_pkg;

    // Default sizes and field widths.
    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 32;
    localparam int VCOUNT_W         = 7;
    localparam int WEIGHT_FIELD_W   = 32;
    localparam int VERTEX_FIELD_W   = 6;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

    // Controller states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_WAVE,
        S_WAIT,
        S_DROP,
        S_OUT
    } t_state;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic init;
        logic mark;
        logic shift;
    } t_cell_ctrl;

endpackage

// File: rtl/core/dpmst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dpmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/dpmst_cell.sv
// One vertex cell: holds key, parent and tree flag, relaxes and passes the min token on.
module dpmst_cell #(
    parameter int MAX_VERTICES = 64,
    parameter int WEIGHT_BITS  = 32,
    parameter int IDX          = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  dpmst_pkg::t_cell_ctrl                  i_ctrl,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]      i_n,
    input  logic [$clog2(MAX_VERTICES)-1:0]        i_u,
    input  logic [$clog2(MAX_VERTICES)-1:0]        i_mark_idx,
    input  logic [WEIGHT_BITS-1:0]                 i_rd_data,
    input  logic                                   i_tok_valid,
    input  logic [WEIGHT_BITS-1:0]                 i_tok_key,
    input  logic [$clog2(MAX_VERTICES)-1:0]        i_tok_idx,
    output logic                                   o_tok_valid,
    output logic [WEIGHT_BITS-1:0]                 o_tok_key,
    output logic [$clog2(MAX_VERTICES)-1:0]        o_tok_idx,
    input  logic [WEIGHT_BITS-1:0]                 i_shift_key,
    input  logic [$clog2(MAX_VERTICES)-1:0]        i_shift_parent,
    output logic [WEIGHT_BITS-1:0]                 o_key,
    output logic [$clog2(MAX_VERTICES)-1:0]        o_parent
);
    import dpmst_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam logic [VW-1:0] MY_IDX = VW'(IDX);
    localparam logic [NW-1:0] MY_IDX_N = NW'(IDX);

    logic [WEIGHT_BITS-1:0] r_key, n_key;
    logic [VW-1:0]          r_parent, n_parent;
    logic                   r_in_tree, n_in_tree;
    logic                   r_tok_valid, n_tok_valid;
    logic [WEIGHT_BITS-1:0] r_tok_key, n_tok_key;
    logic [VW-1:0]          r_tok_idx, n_tok_idx;

    logic                   active;
    logic                   relax;
    logic [WEIGHT_BITS-1:0] relaxed_key;

    // Relax on the row word that arrives with the token, then take part in the min search.
    always_comb begin
        active      = (MY_IDX_N < i_n);
        relax       = i_tok_valid && active && !r_in_tree && (i_rd_data <= r_key);
        relaxed_key = relax ? i_rd_data : r_key;

        n_key     = r_key;
        n_parent  = r_parent;
        n_in_tree = r_in_tree;
        if (i_ctrl.init) begin
            n_in_tree = (IDX == 0);
            n_key     = (IDX == 0) ? '0 : '1;
        end else if (i_ctrl.shift) begin
            n_key    = i_shift_key;
            n_parent = i_shift_parent;
        end else begin
            if (relax) begin
                n_key    = i_rd_data;
                n_parent = i_u;
            end
            if (i_ctrl.mark && (i_mark_idx == MY_IDX)) begin
                n_in_tree = 1'b1;
            end
        end

        // Ties go to the later vertex, so the test is less or equal.
        n_tok_valid = i_tok_valid;
        n_tok_key   = i_tok_key;
        n_tok_idx   = i_tok_idx;
        if (i_tok_valid && active && !r_in_tree && (relaxed_key <= i_tok_key)) begin
            n_tok_key = relaxed_key;
            n_tok_idx = MY_IDX;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tree   <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_in_tree   <= n_in_tree;
            r_tok_valid <= n_tok_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_parent  <= n_parent;
        r_tok_key <= n_tok_key;
        r_tok_idx <= n_tok_idx;
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok_key   = r_tok_key;
    assign o_tok_idx   = r_tok_idx;
    assign o_key       = r_key;
    assign o_parent    = r_parent;

endmodule

// File: rtl/core/dense_prim_mst_core.sv
// Top level of the dense Prim minimum spanning tree core.
// The weight matrix of n vertices streams in row-major, one weight per request and one
// request per cycle while o_in_stall is low, into a weight RAM. The request that
// completes the matrix starts a run of Prim's method from vertex 0, and no further request
// is taken until the last result has been placed in the output register. The run is a row
// of MAX_VERTICES cells, one per vertex; in each of the n-1 rounds a token walks the row
// once while the chosen row of the RAM is read one word per cycle, so each cell relaxes its
// key and the token leaves with the next vertex to add.
// Every round walks the token down the whole cell row, whatever n is. The n-1 parent
// results then shift out of the row at up to one per cycle while i_out_stall allows, the
// last one flagged. Writing the vertex count restarts the matrix load; counts below 2 act
// as 2 and counts above MAX_VERTICES act as MAX_VERTICES.
module dense_prim_mst_core #(
    parameter int MAX_VERTICES = dpmst_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = dpmst_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [dpmst_pkg::VCOUNT_W-1:0]        i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [dpmst_pkg::WEIGHT_FIELD_W-1:0]  i_weight,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [dpmst_pkg::VERTEX_FIELD_W-1:0]  o_vertex,
    output logic [dpmst_pkg::VERTEX_FIELD_W-1:0]  o_parent_vertex,
    output logic [dpmst_pkg::WEIGHT_FIELD_W-1:0]  o_edge_weight,
    output logic                                  o_last
);
    import dpmst_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int AW = 2 * VW;
    localparam logic [VW-1:0] LAST_COL = VW'(MAX_VERTICES - 1);
    localparam logic [VCOUNT_W-1:0] VCOUNT_MAX = VCOUNT_W'(MAX_VERTICES);

    // Registers.
    t_state                  r_state, n_state;
    logic [VCOUNT_W-1:0]     r_vcount, n_vcount;
    logic [VW-1:0]           r_row, n_row;
    logic [VW-1:0]           r_col, n_col;
    logic [VW-1:0]           r_u, n_u;
    logic [VW-1:0]           r_round, n_round;
    logic [VW-1:0]           r_issue, n_issue;
    logic                    r_tok0, n_tok0;
    logic [VW-1:0]           r_v, n_v;
    logic                    r_ov, n_ov;
    logic [VERTEX_FIELD_W-1:0] r_o_vertex, n_o_vertex;
    logic [VERTEX_FIELD_W-1:0] r_o_parent, n_o_parent;
    logic [WEIGHT_FIELD_W-1:0] r_o_weight, n_o_weight;
    logic                    r_o_last, n_o_last;

    // Combinational signals.
    logic [NW-1:0]           vert_n;
    logic [VW-1:0]           n_minus1;
    logic                    accept;
    logic                    out_free;
    t_cell_ctrl              ctrl;
    logic [VW-1:0]           mark_idx;
    logic [WEIGHT_BITS-1:0]  wr_data;
    logic [WEIGHT_BITS-1:0]  rd_data;
    logic [AW-1:0]           raddr;

    // Cell row wiring.
    logic                    tok_valid [MAX_VERTICES+1];
    logic [WEIGHT_BITS-1:0]  tok_key   [MAX_VERTICES+1];
    logic [VW-1:0]           tok_idx   [MAX_VERTICES+1];
    logic [WEIGHT_BITS-1:0]  cell_key  [MAX_VERTICES+1];
    logic [VW-1:0]           cell_par  [MAX_VERTICES+1];

    // Clamp the configured vertex count to the supported range.
    always_comb begin
        if (r_vcount < VCOUNT_W'(2)) begin
            vert_n = NW'(2);
        end else if (r_vcount > VCOUNT_MAX) begin
            vert_n = NW'(MAX_VERTICES);
        end else begin
            vert_n = NW'(r_vcount);
        end
        n_minus1 = VW'(vert_n - NW'(1));
    end

    assign accept   = i_in_valid && (r_state == S_LOAD);
    assign out_free = !r_ov || !i_out_stall;
    assign wr_data  = WEIGHT_BITS'(i_weight);
    assign raddr    = {r_u, r_issue};

    // Sequencer: load, round waves, result unload.
    always_comb begin
        n_state    = r_state;
        n_vcount   = r_vcount;
        n_row      = r_row;
        n_col      = r_col;
        n_u        = r_u;
        n_round    = r_round;
        n_issue    = r_issue;
        n_tok0     = 1'b0;
        n_v        = r_v;
        n_ov       = r_ov && i_out_stall;
        n_o_vertex = r_o_vertex;
        n_o_parent = r_o_parent;
        n_o_weight = r_o_weight;
        n_o_last   = r_o_last;
        ctrl       = '0;
        mark_idx   = tok_idx[MAX_VERTICES];

        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (r_col == n_minus1) begin
                        n_col = '0;
                        if (r_row == n_minus1) begin
                            n_row     = '0;
                            ctrl.init = 1'b1;
                            n_u       = '0;
                            n_round   = '0;
                            n_issue   = '0;
                            n_state   = S_WAVE;
                        end else begin
                            n_row = r_row + VW'(1);
                        end
                    end else begin
                        n_col = r_col + VW'(1);
                    end
                end
            end
            S_WAVE: begin
                n_tok0  = (r_issue == '0);
                n_issue = r_issue + VW'(1);
                if (r_issue == LAST_COL) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (tok_valid[MAX_VERTICES]) begin
                    if (NW'(r_round) == NW'(vert_n - NW'(2))) begin
                        n_state = S_DROP;
                    end else begin
                        ctrl.mark = 1'b1;
                        n_u       = tok_idx[MAX_VERTICES];
                        n_round   = r_round + VW'(1);
                        n_issue   = '0;
                        n_state   = S_WAVE;
                    end
                end
            end
            S_DROP: begin
                ctrl.shift = 1'b1;
                n_v        = VW'(1);
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    ctrl.shift = 1'b1;
                    n_ov       = 1'b1;
                    n_o_vertex = VERTEX_FIELD_W'(r_v);
                    n_o_parent = VERTEX_FIELD_W'(cell_par[0]);
                    n_o_weight = WEIGHT_FIELD_W'(cell_key[0]);
                    n_o_last   = (r_v == n_minus1);
                    n_v        = r_v + VW'(1);
                    if (r_v == n_minus1) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // A count write restarts the matrix load.
        if (i_cfg_we) begin
            n_vcount = i_cfg_wdata;
            n_row    = '0;
            n_col    = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_vcount <= VCOUNT_RESET;
            r_row    <= '0;
            r_col    <= '0;
            r_u      <= '0;
            r_round  <= '0;
            r_issue  <= '0;
            r_tok0   <= 1'b0;
            r_v      <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vcount <= n_vcount;
            r_row    <= n_row;
            r_col    <= n_col;
            r_u      <= n_u;
            r_round  <= n_round;
            r_issue  <= n_issue;
            r_tok0   <= n_tok0;
            r_v      <= n_v;
            r_ov     <= n_ov;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_o_vertex <= n_o_vertex;
        r_o_parent <= n_o_parent;
        r_o_weight <= n_o_weight;
        r_o_last   <= n_o_last;
    end

    // Weight matrix store, one row per vertex.
    dpmst_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (1 << AW)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr ({r_row, r_col}),
        .i_wdata (wr_data),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // Token enters the head of the row; unused tail feeds the unload shift.
    assign tok_valid[0]           = r_tok0;
    assign tok_key[0]             = '1;
    assign tok_idx[0]             = '0;
    assign cell_key[MAX_VERTICES] = '1;
    assign cell_par[MAX_VERTICES] = '0;

    // Row of vertex cells.
    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        dpmst_cell #(
            .MAX_VERTICES (MAX_VERTICES),
            .WEIGHT_BITS  (WEIGHT_BITS),
            .IDX          (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (ctrl),
            .i_n            (vert_n),
            .i_u            (r_u),
            .i_mark_idx     (mark_idx),
            .i_rd_data      (rd_data),
            .i_tok_valid    (tok_valid[g]),
            .i_tok_key      (tok_key[g]),
            .i_tok_idx      (tok_idx[g]),
            .o_tok_valid    (tok_valid[g+1]),
            .o_tok_key      (tok_key[g+1]),
            .o_tok_idx      (tok_idx[g+1]),
            .i_shift_key    (cell_key[g+1]),
            .i_shift_parent (cell_par[g+1]),
            .o_key          (cell_key[g]),
            .o_parent       (cell_par[g])
        );
    end

    assign o_in_stall      = (r_state != S_LOAD);
    assign o_out_valid     = r_ov;
    assign o_vertex        = r_o_vertex;
    assign o_parent_vertex = r_o_parent;
    assign o_edge_weight   = r_o_weight;
    assign o_last          = r_o_last;

endmodule

// File: sim/tb_dense_prim_mst_core.sv
// Self-checking testbench of the dense Prim spanning tree core, with its own tree predictor.
module tb_dense_prim_mst_core;
    timeunit 1ns;
    timeprecision 1ps;
    import dpmst_pkg::*;

    localparam int NV_MAX = MAX_VERTICES_DEF;
    localparam logic [31:0] W_INF = 32'hFFFF_FFFF;

    // One parent result as the block reports it.
    typedef struct {
        logic [VERTEX_FIELD_W-1:0] vertex;
        logic [VERTEX_FIELD_W-1:0] parent;
        logic [WEIGHT_FIELD_W-1:0] weight;
        logic                      last;
    } t_parent_rec;

    // One row of the directed stimulus table.
    typedef enum logic {ROW_WEIGHT, ROW_COUNT} t_row_kind;
    typedef struct {
        t_row_kind   kind;
        logic [31:0] value;
        bit          typed;
        t_parent_rec want;
    } t_stim_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [VCOUNT_W-1:0]       i_cfg_wdata = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [WEIGHT_FIELD_W-1:0] i_weight = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [VERTEX_FIELD_W-1:0] o_vertex;
    logic [VERTEX_FIELD_W-1:0] o_parent_vertex;
    logic [WEIGHT_FIELD_W-1:0] o_edge_weight;
    logic                      o_last;

    dense_prim_mst_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_weight(i_weight),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_vertex(o_vertex), .o_parent_vertex(o_parent_vertex),
        .o_edge_weight(o_edge_weight), .o_last(o_last)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic [31:0]         mdl_weights [NV_MAX*NV_MAX];
    logic [31:0]         mdl_key     [NV_MAX];
    bit                  mdl_in_tree [NV_MAX];
    logic [5:0]          mdl_parent  [NV_MAX];
    int unsigned         mdl_load_pos;
    logic [VCOUNT_W-1:0] mdl_count;

    t_parent_rec expected_parents [$];
    t_parent_rec fresh_parents [$];

    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          runs_done = 0;
    int unsigned cycle_no = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    // No random idling inside this window of cycles.
    function automatic bit quiet_now();
        return cycle_no >= 2000 && cycle_no < 5000;
    endfunction

    function automatic bit idle_roll();
        return !quiet_now() && ($urandom_range(99) < 13);
    endfunction

    function automatic int active_count();
        int n;
        n = mdl_count;
        if (n < 2) n = 2;
        if (n > NV_MAX) n = NV_MAX;
        return n;
    endfunction

    // Prim's method from vertex 0; results go to fresh_parents.
    task automatic grow_tree(input int n);
        logic [31:0] lowest;
        logic [31:0] w;
        int          u;
        t_parent_rec r;
        for (int v = 0; v < NV_MAX; v++) begin
            mdl_key[v] = W_INF;
            mdl_in_tree[v] = 1'b0;
        end
        mdl_key[0] = '0;
        mdl_parent[0] = '0;
        for (int rnd = 0; rnd + 1 < n; rnd++) begin
            lowest = W_INF;
            u = 0;
            // Ties go to the highest index.
            for (int v = 0; v < n; v++) begin
                if (!mdl_in_tree[v] && mdl_key[v] <= lowest) begin
                    lowest = mdl_key[v];
                    u = v;
                end
            end
            mdl_in_tree[u] = 1'b1;
            // An equal weight re-parents.
            for (int v = 0; v < n; v++) begin
                w = mdl_weights[u*NV_MAX + v];
                if (!mdl_in_tree[v] && w <= mdl_key[v]) begin
                    mdl_parent[v] = u[5:0];
                    mdl_key[v] = w;
                end
            end
        end
        for (int v = 1; v < n; v++) begin
            r.vertex = v[5:0];
            r.parent = mdl_parent[v];
            r.weight = mdl_key[v];
            r.last = (v + 1 == n);
            fresh_parents.push_back(r);
        end
        runs_done++;
    endtask

    // Store one weight and start a run when the matrix is complete.
    task automatic load_weight(input logic [31:0] w);
        int n;
        int unsigned total;
        n = active_count();
        total = n * n;
        if (mdl_load_pos >= total) mdl_load_pos = 0;
        mdl_weights[(mdl_load_pos / n)*NV_MAX + (mdl_load_pos % n)] = w;
        if (mdl_load_pos + 1 == total) begin
            mdl_load_pos = 0;
            grow_tree(n);
        end else begin
            mdl_load_pos = (mdl_load_pos + 1) & 12'hFFF;
        end
    endtask

    // Offer one weight request; a typed row replaces the predicted results.
    task automatic send_weight(input logic [31:0] w, input bit typed, input t_parent_rec want);
        @(negedge i_clk);
        while (idle_roll()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_weight <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        fresh_parents.delete();
        load_weight(w);
        if (typed) begin
            fresh_parents.delete();
            fresh_parents.push_back(want);
        end
        foreach (fresh_parents[k]) expected_parents.push_back(fresh_parents[k]);
        items_sent++;
    endtask

    // Write the vertex count once the block has gone quiet.
    task automatic write_count(input logic [VCOUNT_W-1:0] value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (expected_parents.size() == 0);
        repeat (200) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_count = value;
        mdl_load_pos = 0;
    endtask

    function automatic logic [31:0] pick_weight();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30) return $urandom_range(3, 1);
        if (roll < 40) return W_INF;
        if (roll < 50) return '0;
        return $urandom;
    endfunction

    // Receiver side: random stalls, one long hold-off on request.
    always @(negedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 3000;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_roll();
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_parent_rec e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_parents.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: vertex %0d parent %0d weight %h last %0d",
                             o_vertex, o_parent_vertex, o_edge_weight, o_last);
            end else begin
                e = expected_parents.pop_front();
                if (o_vertex !== e.vertex || o_parent_vertex !== e.parent ||
                    o_edge_weight !== e.weight || o_last !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp v %0d p %0d w %h l %0d, got v %0d p %0d w %h l %0d",
                                 e.vertex, e.parent, e.weight, e.last,
                                 o_vertex, o_parent_vertex, o_edge_weight, o_last);
                end
            end
        end
    end

    // Directed table: clamped counts, a restarted load, ties and infinite weights.
    t_stim_row directed [$];

    function automatic t_stim_row row_w(input logic [31:0] v);
        t_stim_row r;
        r.kind = ROW_WEIGHT;
        r.value = v;
        r.typed = 1'b0;
        r.want = '{default: '0};
        return r;
    endfunction

    function automatic t_stim_row row_c(input logic [31:0] v);
        t_stim_row r;
        r = row_w(v);
        r.kind = ROW_COUNT;
        return r;
    endfunction

    function automatic t_stim_row row_t(input logic [31:0] v, input logic [31:0] ew);
        t_stim_row r;
        r = row_w(v);
        r.typed = 1'b1;
        r.want = '{vertex: 6'd1, parent: 6'd0, weight: ew, last: 1'b1};
        return r;
    endfunction

    initial begin
        int n;
        int part;
        t_parent_rec none;
        none = '{default: '0};
        foreach (mdl_weights[k]) mdl_weights[k] = '0;
        foreach (mdl_parent[k]) mdl_parent[k] = '0;
        mdl_load_pos = 0;
        mdl_count = VCOUNT_RESET;

        // Count 0 acts as two vertices.
        directed.push_back(row_c(0));
        directed.push_back(row_w(0));
        directed.push_back(row_w(32'h0001_0000));
        directed.push_back(row_w(32'h0001_0000));
        directed.push_back(row_t(0, 32'h0001_0000));
        // Count 1 acts as two; an unreachable vertex still gets a parent.
        directed.push_back(row_c(1));
        directed.push_back(row_w(W_INF));
        directed.push_back(row_w(W_INF));
        directed.push_back(row_w(W_INF));
        directed.push_back(row_t(W_INF, W_INF));
        // Count 127 acts as the maximum; the rewrite restarts the partial load.
        directed.push_back(row_c(127));
        directed.push_back(row_w(32'h1234_5678));
        directed.push_back(row_w(32'h8765_4321));
        directed.push_back(row_c(3));
        for (int k = 0; k < 9; k++) directed.push_back(row_w(32'd7));
        // Mixed extremes on three vertices.
        for (int k = 0; k < 9; k++)
            directed.push_back(row_w((k % 3 == 0) ? 32'd0 : ((k % 2) ? W_INF : 32'd1)));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            if (directed[k].kind == ROW_COUNT)
                write_count(directed[k].value[VCOUNT_W-1:0]);
            else
                send_weight(directed[k].value, directed[k].typed, directed[k].want);
        end

        // Random graphs, mostly small and well formed, some loads cut short.
        part = items_sent;
        while (items_sent - part < 270 || results_seen < 40) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 2);
            write_count(n[VCOUNT_W-1:0]);
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(n*n - 1, 1)) send_weight(pick_weight(), 1'b0, none);
                write_count(n[VCOUNT_W-1:0]);
            end
            if (items_sent - part > 100) hold_req = 1'b1;
            for (int k = 0; k < n*n; k++) send_weight(pick_weight(), 1'b0, none);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (expected_parents.size() == 0);
        repeat (300) @(posedge i_clk);
        if (expected_parents.size() != 0) errors += expected_parents.size();

        $display("run covered %0d weight requests, %0d spanning tree runs, %0d parent results",
                 items_sent, runs_done, results_seen);
        $display("graphs of 2 to 16 vertices, clamped counts, ties, infinite weights, restarts");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard limit on the run.
    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
